>>> rtl/dpsf_pkg.sv
// Package for the dense Prim spanning forest block.
// Holds opcodes, register indexes, size constants and the node record type; no dependencies.
`timescale 1ns / 1ps
package dpsf_pkg;
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_BUILD = 1'b1;
    localparam logic [0:0] REG_NODE_COUNT = 1'b0;
    localparam int NODE_COUNT_RESET = 64;
    localparam int MAX_NODES = 64;
    localparam int COST_BITS = 16;
    localparam int NODE_BITS = $clog2(MAX_NODES);

    // one node queue slot: node id with its best link cost and parent
    typedef struct packed {
        logic [NODE_BITS-1:0] node;
        logic [COST_BITS-1:0] best;
        logic [NODE_BITS-1:0] parent;
    } t_node_rec;
endpackage

>>> rtl/dpsf_cost_mem.sv
// Cost store: one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
module dpsf_cost_mem #(
    parameter int ADDR_BITS = 12,
    parameter int COST_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [COST_BITS-1:0] i_wdata,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [COST_BITS-1:0] o_rdata
);
    logic [COST_BITS-1:0] r_mem [0:(1<<ADDR_BITS)-1];
    logic [COST_BITS-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

>>> rtl/dense_prim_spanning_forest_top.sv
// Top level of the dense Prim spanning forest block.
// Uses dpsf_pkg and dpsf_cost_mem.
//
// channel | dir | accepted when                  | payload
// s_axis  | in  | s_axis_tvalid && s_axis_tready | tdata: opcode, row_node, col_node, arc_cost
// m_axis  | out | m_axis_tvalid && m_axis_tready | tdata: settled, parent, link_cost; tlast
// apb     | in  | psel && penable && pwrite      | node_count at byte address 0
//
// A cost write or a build is taken only while no build runs. A build of n nodes
// first loads the node queue, then for each settled node m emits it and, except
// after the last, relaxes the remaining nodes through the two-stage memory read.
// The relax pass also picks the next cheapest node. Output stalls hold the
// sequencer at the emit state. Reset is synchronous; the cost store has no reset.
`timescale 1ns / 1ps
module dense_prim_spanning_forest_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // opcode[0], row[6:1], col[12:7], cost[28:13]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // settled[5:0], parent[11:6], cost[27:12]
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int NB = dpsf_pkg::NODE_BITS;
    localparam int CB = NB + 1;
    localparam int CW = dpsf_pkg::COST_BITS;
    localparam int MAXN = dpsf_pkg::MAX_NODES;
    localparam logic [CW-1:0] INF = '1;
    localparam logic [1:0] A_NODE_COUNT = 2'(4 * int'(dpsf_pkg::REG_NODE_COUNT));
    localparam logic [1:0] S_IDLE = 2'd0, S_INIT = 2'd1, S_EMIT = 2'd2, S_UPD = 2'd3;

    logic [1:0]    r_state;
    logic [6:0]    r_cnt_reg;
    logic [CB-1:0] r_n, r_m, r_k, r_pos;
    logic [NB-1:0] r_u;
    dpsf_pkg::t_node_rec r_pick, r_front, r_out;
    logic          r_oval, r_olast;
    logic          r_s1_vld, r_s2_vld;
    logic [CB-1:0] r_s1_pos, r_s2_pos;
    dpsf_pkg::t_node_rec r_s2_rec;
    dpsf_pkg::t_node_rec r_node_mem [0:MAXN-1];
    dpsf_pkg::t_node_rec r_node_rd;

    logic [5:0]  in_row, in_col;
    logic [15:0] in_cost;
    logic        wr_ok, build_ok, issue, emit_fire;
    logic [CW-1:0] rdata;
    logic [2*NB-1:0] raddr;
    dpsf_pkg::t_node_rec upd_rec, nm_wdata;
    logic          nm_we;
    logic [NB-1:0] nm_waddr;

    assign in_row  = s_axis_tdata[6:1];
    assign in_col  = s_axis_tdata[12:7];
    assign in_cost = s_axis_tdata[28:13];
    assign s_axis_tready = (r_state == S_IDLE);
    assign wr_ok = s_axis_tvalid && s_axis_tready && (s_axis_tdata[0] == dpsf_pkg::OP_WRITE)
        && ({26'd0, in_row} < 32'(MAXN)) && ({26'd0, in_col} < 32'(MAXN));
    assign build_ok = s_axis_tvalid && s_axis_tready
        && (s_axis_tdata[0] == dpsf_pkg::OP_BUILD);
    assign issue = (r_state == S_UPD) && (r_k < r_n);
    assign emit_fire = (r_state == S_EMIT) && (!r_oval || m_axis_tready);
    // cost of arc from the node just read to the node settled last
    assign raddr = {r_node_rd.node, r_u};

    dpsf_cost_mem #(.ADDR_BITS(2*NB), .COST_BITS(CW)) u_mem (
        .i_clk(i_clk), .i_we(wr_ok),
        .i_waddr({in_row[NB-1:0], in_col[NB-1:0]}),
        .i_wdata(CW'(in_cost)), .i_raddr(raddr), .o_rdata(rdata));

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == A_NODE_COUNT) ? {25'd0, r_cnt_reg} : 32'd0;

    // relax the queued node against the settled one
    always_comb begin
        upd_rec = r_s2_rec;
        if (rdata < r_s2_rec.best) begin
            upd_rec.best = rdata;
            upd_rec.parent = r_u;
        end
    end

    // node queue write port: load, swap on emit, write back on relax
    always_comb begin
        nm_we = 1'b0;
        nm_waddr = r_k[NB-1:0];
        nm_wdata = '{node: r_k[NB-1:0], best: INF, parent: r_k[NB-1:0]};
        case (r_state)
            S_INIT: begin
                nm_we = 1'b1;
            end
            S_EMIT: begin
                nm_we = emit_fire && (r_pos != r_m);
                nm_waddr = r_pos[NB-1:0];
                nm_wdata = r_front;
            end
            S_UPD: begin
                nm_we = r_s2_vld;
                nm_waddr = r_s2_pos[NB-1:0];
                nm_wdata = upd_rec;
            end
            default: begin
                nm_we = 1'b0;
            end
        endcase
    end

    // node queue memory with registered read
    always_ff @(posedge i_clk) begin
        if (nm_we) begin
            r_node_mem[nm_waddr] <= nm_wdata;
        end
        r_node_rd <= r_node_mem[r_k[NB-1:0]];
    end

    // build sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt_reg <= 7'(dpsf_pkg::NODE_COUNT_RESET);
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == A_NODE_COUNT) begin
                r_cnt_reg <= pwdata[6:0];
            end
            // advance the relax read pipeline
            r_s1_vld <= issue;
            r_s1_pos <= r_k;
            r_s2_vld <= r_s1_vld;
            r_s2_pos <= r_s1_pos;
            r_s2_rec <= r_node_rd;
            case (r_state)
                S_IDLE: begin
                    if (build_ok) begin
                        r_n <= (r_cnt_reg > 7'(MAXN)) ? CB'(MAXN) : CB'(r_cnt_reg);
                        r_k <= '0;
                        r_state <= (r_cnt_reg == 7'd0) ? S_IDLE : S_INIT;
                    end
                end
                S_INIT: begin
                    if (r_k + 1'b1 == r_n) begin
                        r_m <= '0;
                        r_pos <= '0;
                        r_pick <= '{node: '0, best: INF, parent: '0};
                        r_front <= '{node: '0, best: INF, parent: '0};
                        r_state <= S_EMIT;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (emit_fire) begin
                        r_u <= r_pick.node;
                        r_k <= r_m + 1'b1;
                        r_state <= (r_m + 1'b1 == r_n) ? S_IDLE : S_UPD;
                    end
                end
                S_UPD: begin
                    if (issue) begin
                        r_k <= r_k + 1'b1;
                    end
                    // strict less-than pick, first slot taken as the start
                    if (r_s2_vld) begin
                        if (r_s2_pos == r_m + 1'b1) begin
                            r_front <= upd_rec;
                            r_pick <= upd_rec;
                            r_pos <= r_s2_pos;
                        end else if (upd_rec.best < r_pick.best) begin
                            r_pick <= upd_rec;
                            r_pos <= r_s2_pos;
                        end
                        if (r_s2_pos + 1'b1 == r_n) begin
                            r_m <= r_m + 1'b1;
                            r_state <= S_EMIT;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register: load on emit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (emit_fire) begin
            r_oval <= 1'b1;
        end else if (m_axis_tready) begin
            r_oval <= 1'b0;
        end
        if (emit_fire) begin
            r_out <= r_pick;
            r_olast <= (r_m + 1'b1 == r_n);
        end
    end

    assign m_axis_tvalid = r_oval;
    assign m_axis_tlast = r_olast;
    assign m_axis_tdata = {4'd0, r_out.best, r_out.parent, r_out.node};

    // no input accepted while a build runs
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready) else $error("accept during build");
    // output holds while stalled
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("output dropped");
    // output data holds while stalled
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output changed under stall");
    // relax only while nodes remain after the settled one
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> (r_m + 1'b1 < r_n)) else $error("step past node count");
    // relax writes stay in the unsettled part of the queue
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && r_s2_vld) |-> (r_s2_pos > r_m)) else $error("write to settled slot");
endmodule
